// ----- rtl/rrs_pkg.sv -----
// Package for the ratio rank sorter.
// Shared widths, the record word passed from front to back, and the back FSM states.
package rrs_pkg;

  localparam int SuccW   = 31;
  localparam int TotalW  = 32;
  localparam int RecNumW = 7;
  localparam int ProdW   = SuccW + TotalW;

  typedef struct packed {
    logic [SuccW-1:0]  success;
    logic [TotalW-1:0] total;   // success + failure, zero forced to one
    logic              last;
  } rec_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD,
    ST_MUL,
    ST_CMP,
    ST_EMIT
  } state_e;

endpackage

// ----- rtl/rrs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rrs_front.sv -----
// Front end: accepts records, forms the rate denominator, queues them for the back end.
// Depends on rrs_pkg.
module rrs_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [rrs_pkg::SuccW-1:0] success_i,
  input  logic [rrs_pkg::SuccW-1:0] failure_i,
  input  logic                      last_i,
  output logic                      rec_valid_o,
  input  logic                      rec_ready_i,
  output rrs_pkg::rec_t             rec_o
);
  import rrs_pkg::*;

  rec_t             mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;
  logic [TotalW-1:0] sum;
  rec_t             rec_in;

  always_comb begin
    sum = TotalW'(success_i) + TotalW'(failure_i);
    rec_in.success = success_i;
    rec_in.total   = (sum == '0) ? TotalW'(1) : sum;
    rec_in.last    = last_i;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign rec_valid_o = (cnt_q != 2'd0);
  assign rec_o       = mem_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = rec_valid_o & rec_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= rec_in;
    end
  end

endmodule

// ----- rtl/rrs_back.sv -----
// Back end: stores the set in a RAM, then emits it by repeated best-rate selection scans.
// Depends on rrs_pkg and rrs_ram.
module rrs_back #(
  parameter int MAX_RECORDS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rec_valid_i,
  output logic                        rec_ready_o,
  input  rrs_pkg::rec_t               rec_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rrs_pkg::RecNumW-1:0] out_num_o,
  output logic                        out_last_o
);
  import rrs_pkg::*;

  localparam int IW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int DW = SuccW + TotalW;

  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [IW-1:0]        scan_q, scan_d;
  logic [IW-1:0]        rank_q, rank_d;
  logic [MAX_RECORDS-1:0] done_q, done_d;
  logic                 best_vld_q, best_vld_d;
  logic [IW-1:0]        best_idx_q, best_idx_d;
  logic [SuccW-1:0]     best_s_q, best_s_d;
  logic [TotalW-1:0]    best_t_q, best_t_d;
  logic [SuccW-1:0]     cand_s_q, cand_s_d;
  logic [TotalW-1:0]    cand_t_q, cand_t_d;
  logic                 cand_ok_q, cand_ok_d;
  logic [ProdW-1:0]     prod_c_q, prod_c_d;
  logic [ProdW-1:0]     prod_b_q, prod_b_d;
  logic                 out_vld_q, out_vld_d;
  logic [RecNumW-1:0]   out_num_q, out_num_d;
  logic                 out_last_q, out_last_d;

  logic                 ram_we;
  logic [DW-1:0]        ram_rdata;
  logic [SuccW-1:0]     rd_s;
  logic [TotalW-1:0]    rd_t;
  logic                 full, scan_end, rank_end, take, out_free;

  rrs_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_RECORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i ({rec_i.total, rec_i.success}),
    .raddr_i (scan_d),
    .rdata_o (ram_rdata)
  );

  assign rd_s     = ram_rdata[SuccW-1:0];
  assign rd_t     = ram_rdata[DW-1:SuccW];
  assign full     = (cnt_q == CW'(MAX_RECORDS));
  assign scan_end = ((CW'(scan_q) + CW'(1)) == cnt_q);
  assign rank_end = ((CW'(rank_q) + CW'(1)) == cnt_q);
  assign take     = cand_ok_q & (~best_vld_q | (prod_c_q > prod_b_q));
  assign out_free = ~out_vld_q | out_ready_i;
  assign rec_ready_o = (state_q == ST_LOAD);
  assign ram_we   = (state_q == ST_LOAD) & rec_valid_i & ~full;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    scan_d     = scan_q;
    rank_d     = rank_q;
    done_d     = done_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_s_d   = best_s_q;
    best_t_d   = best_t_q;
    cand_s_d   = cand_s_q;
    cand_t_d   = cand_t_q;
    cand_ok_d  = cand_ok_q;
    prod_c_d   = prod_c_q;
    prod_b_d   = prod_b_q;
    out_vld_d  = out_vld_q & ~out_ready_i;
    out_num_d  = out_num_q;
    out_last_d = out_last_q;

    case (state_q)
      ST_LOAD: begin
        if (rec_valid_i) begin
          if (!full) begin
            cnt_d = cnt_q + CW'(1);
          end
          if (rec_i.last) begin
            scan_d     = '0;
            rank_d     = '0;
            best_vld_d = 1'b0;
            state_d    = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cand_s_d  = rd_s;
        cand_t_d  = rd_t;
        cand_ok_d = ~done_q[scan_q];
        prod_c_d  = ProdW'(rd_s) * ProdW'(best_t_q);
        prod_b_d  = ProdW'(best_s_q) * ProdW'(rd_t);
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        if (take) begin
          best_vld_d = 1'b1;
          best_idx_d = scan_q;
          best_s_d   = cand_s_q;
          best_t_d   = cand_t_q;
        end
        if (scan_end) begin
          state_d = ST_EMIT;
        end else begin
          scan_d  = scan_q + IW'(1);
          state_d = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_num_d  = RecNumW'(best_idx_q) + RecNumW'(1);
          out_last_d = rank_end;
          done_d[best_idx_q] = 1'b1;
          if (rank_end) begin
            cnt_d   = '0;
            done_d  = '0;
            state_d = ST_LOAD;
          end else begin
            rank_d     = rank_q + IW'(1);
            scan_d     = '0;
            best_vld_d = 1'b0;
            state_d    = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      cnt_q      <= '0;
      scan_q     <= '0;
      rank_q     <= '0;
      done_q     <= '0;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      scan_q     <= scan_d;
      rank_q     <= rank_d;
      done_q     <= done_d;
      best_vld_q <= best_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_s_q   <= best_s_d;
    best_t_q   <= best_t_d;
    cand_s_q   <= cand_s_d;
    cand_t_q   <= cand_t_d;
    cand_ok_q  <= cand_ok_d;
    prod_c_q   <= prod_c_d;
    prod_b_q   <= prod_b_d;
    out_num_q  <= out_num_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_num_o   = out_num_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- rtl/ratio_rank_sorter.sv -----
// Top level of the ratio rank sorter: stream ports, front end and back end.
// Depends on rrs_pkg, rrs_front, rrs_back (and rrs_ram below it).
//
// Records (success, failure, tlast) load at one word per cycle while the
// back end is loading, into a RAM of MAX_RECORDS entries; records beyond
// that are dropped, though a dropped tlast still closes the set. After the
// tlast word the set of n records is emitted as record numbers, highest
// success/(success+failure) first, ties by arrival order, both counts zero
// ranking as rate zero. Output is produced by n selection passes over the
// RAM (one RAM read port and one pair of 31x32 multipliers per candidate);
// input words for the next set are held in a two-word queue meanwhile and
// back-pressured beyond that. No clearing pass.
module ratio_rank_sorter #(
  parameter int MAX_RECORDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // success_count[30:0], failure_count[61:31], zero
  input  logic        s_axis_tlast_i,   // last_record
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // record_number[6:0], zero
  output logic        m_axis_tlast_o    // last_out
);
  import rrs_pkg::*;

  logic               rec_valid;
  logic               rec_ready;
  rec_t               rec;
  logic [RecNumW-1:0] out_num;

  rrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .success_i   (s_axis_tdata_i[SuccW-1:0]),
    .failure_i   (s_axis_tdata_i[2*SuccW-1:SuccW]),
    .last_i      (s_axis_tlast_i),
    .rec_valid_o (rec_valid),
    .rec_ready_i (rec_ready),
    .rec_o       (rec)
  );

  rrs_back #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_ready_o (rec_ready),
    .rec_i       (rec),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_num_o   (out_num),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, out_num};

endmodule
